### sv/log_record_deframer_checker_unit_defines.svh
// Assertion macros for the log record deframer checker.
`ifndef LOG_RECORD_DEFRAMER_CHECKER_UNIT_DEFINES_SVH
`define LOG_RECORD_DEFRAMER_CHECKER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while in reset
`define LRDC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset
`define LRDC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/lrdc_pkg.sv
// Types, constants and the CRC step for the log record deframer checker.
`default_nettype none

package lrdc_pkg;

    // CRC-32, reflected
    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [31:0] CRC_ONES = 32'hFFFF_FFFF;

    // op byte + key length + value length
    localparam int HDR_BYTES = 1 + 2 + 4;

    // result field widths
    localparam int VEND_W = 48;

    // output queue
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    // register indexes
    localparam logic [0:0] REG_PUT_OP = 1'b0;
    localparam logic [0:0] REG_DEL_OP = 1'b1;

    typedef enum logic [1:0] {
        PH_LEN,
        PH_PAY,
        PH_CRC
    } t_phase;

    typedef enum logic [2:0] {
        EV_HEADER = 3'd0,
        EV_KEY    = 3'd1,
        EV_VALUE  = 3'd2,
        EV_GOOD   = 3'd3,
        EV_END    = 3'd4
    } t_event;

    typedef enum logic [2:0] {
        ST_CLEAN    = 3'd0,
        ST_TORN_LEN = 3'd1,
        ST_TORN_REC = 3'd2,
        ST_CRC      = 3'd3,
        ST_SHORT    = 3'd4,
        ST_MISMATCH = 3'd5,
        ST_BAD_OP   = 3'd6
    } t_status;

    typedef struct packed {
        t_event              ev;
        logic [7:0]          op_code;
        logic [15:0]         key_length;
        logic [31:0]         value_length;
        logic [7:0]          payload_byte;
        t_status             status;
        logic [VEND_W-1:0]   valid_end;
    } t_result;

    // One byte through the reflected CRC-32
    function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] x;
        x = c ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            x = x[0] ? ((x >> 1) ^ CRC_POLY) : (x >> 1);
        end
        return x;
    endfunction

endpackage

`default_nettype wire

### sv/lrdc_front.sv
// Front end: parses log bytes, checks records and forms result items.
`default_nettype none

module lrdc_front #(
    parameter int OFFSET_BITS = 48
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [0:0]       i_cfg_idx,
    input  wire logic [7:0]       i_cfg_data,
    input  wire logic             i_accept,
    input  wire logic             i_kind,
    input  wire logic [7:0]       i_log_byte,
    output logic                  o_res_valid,
    output lrdc_pkg::t_result     o_res
);

    localparam int VW = lrdc_pkg::VEND_W;

    // configuration
    logic [7:0] r_put_op;
    logic [7:0] r_del_op;

    // parser state
    lrdc_pkg::t_phase          r_phase,       n_phase;
    logic [31:0]               r_field_cnt,   n_field_cnt;
    logic [31:0]               r_pay_size,    n_pay_size;
    logic [7:0]                r_rec_op,      n_rec_op;
    logic [15:0]               r_key_len,     n_key_len;
    logic [31:0]               r_val_len,     n_val_len;
    logic [16:0]               r_key_end,     n_key_end;
    logic [32:0]               r_val_end,     n_val_end;
    logic [31:0]               r_crc,         n_crc;
    logic [31:0]               r_rx_crc,      n_rx_crc;
    logic [OFFSET_BITS-1:0]    r_stream_off,  n_stream_off;
    logic [OFFSET_BITS-1:0]    r_good_end,    n_good_end;
    lrdc_pkg::t_status         r_stop,        n_stop;

    logic [OFFSET_BITS-1:0]    off_inc;
    logic [OFFSET_BITS+VW-1:0] good_ext;
    logic [OFFSET_BITS+VW-1:0] inc_ext;
    logic [32:0]               cnt_next;
    logic [31:0]               val_len_new;
    logic [31:0]               rx_crc_new;
    logic [31:0]               size_new;
    lrdc_pkg::t_status         end_st;

    // Saturating offset and its 48-bit view
    assign off_inc  = (r_stream_off == {OFFSET_BITS{1'b1}}) ? r_stream_off
                                                            : r_stream_off + 1'b1;
    assign good_ext = {{VW{1'b0}}, r_good_end};
    assign inc_ext  = {{VW{1'b0}}, off_inc};
    assign cnt_next = {1'b0, r_field_cnt} + 33'd1;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_put_op <= 8'd0;
            r_del_op <= 8'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                lrdc_pkg::REG_PUT_OP: r_put_op <= i_cfg_data;
                lrdc_pkg::REG_DEL_OP: r_del_op <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Parser state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= lrdc_pkg::PH_LEN;
            r_field_cnt  <= '0;
            r_pay_size   <= '0;
            r_rec_op     <= '0;
            r_key_len    <= '0;
            r_val_len    <= '0;
            r_key_end    <= '0;
            r_val_end    <= '0;
            r_crc        <= lrdc_pkg::CRC_ONES;
            r_rx_crc     <= '0;
            r_stream_off <= '0;
            r_good_end   <= '0;
            r_stop       <= lrdc_pkg::ST_CLEAN;
        end else begin
            r_phase      <= n_phase;
            r_field_cnt  <= n_field_cnt;
            r_pay_size   <= n_pay_size;
            r_rec_op     <= n_rec_op;
            r_key_len    <= n_key_len;
            r_val_len    <= n_val_len;
            r_key_end    <= n_key_end;
            r_val_end    <= n_val_end;
            r_crc        <= n_crc;
            r_rx_crc     <= n_rx_crc;
            r_stream_off <= n_stream_off;
            r_good_end   <= n_good_end;
            r_stop       <= n_stop;
        end
    end

    // Next state and result item
    always_comb begin
        n_phase      = r_phase;
        n_field_cnt  = r_field_cnt;
        n_pay_size   = r_pay_size;
        n_rec_op     = r_rec_op;
        n_key_len    = r_key_len;
        n_val_len    = r_val_len;
        n_key_end    = r_key_end;
        n_val_end    = r_val_end;
        n_crc        = r_crc;
        n_rx_crc     = r_rx_crc;
        n_stream_off = r_stream_off;
        n_good_end   = r_good_end;
        n_stop       = r_stop;
        o_res_valid  = 1'b0;
        o_res        = '0;
        end_st       = r_stop;
        val_len_new  = {i_log_byte, r_val_len[23:0]};
        rx_crc_new   = {i_log_byte, r_rx_crc[23:0]};
        size_new     = r_pay_size;
        for (int j = 0; j < 4; j++) begin
            if (r_field_cnt[1:0] == j[1:0]) begin
                size_new[8*j +: 8] = i_log_byte;
            end
        end

        if (i_accept) begin
            if (i_kind) begin
                // end of log: report, and stop unless at a record boundary
                if (r_stop == lrdc_pkg::ST_CLEAN) begin
                    if (r_phase == lrdc_pkg::PH_LEN && r_field_cnt == '0) begin
                        end_st = lrdc_pkg::ST_CLEAN;
                    end else if (r_phase == lrdc_pkg::PH_LEN) begin
                        end_st = lrdc_pkg::ST_TORN_LEN;
                    end else begin
                        end_st = lrdc_pkg::ST_TORN_REC;
                    end
                    n_stop = end_st;
                end
                o_res_valid     = 1'b1;
                o_res.ev        = lrdc_pkg::EV_END;
                o_res.status    = end_st;
                o_res.valid_end = good_ext[VW-1:0];
            end else if (r_stop == lrdc_pkg::ST_CLEAN) begin
                n_stream_off = off_inc;
                case (r_phase)
                    // little-endian payload length
                    lrdc_pkg::PH_LEN: begin
                        n_pay_size = size_new;
                        if (r_field_cnt[1:0] == 2'd3) begin
                            n_field_cnt = '0;
                            n_phase = (size_new == '0) ? lrdc_pkg::PH_CRC
                                                       : lrdc_pkg::PH_PAY;
                        end else begin
                            n_field_cnt = cnt_next[31:0];
                        end
                    end

                    // payload: header fields, then key and value bytes
                    lrdc_pkg::PH_PAY: begin
                        n_crc = lrdc_pkg::crc_byte(r_crc, i_log_byte);
                        if (cnt_next >= {1'b0, r_pay_size}) begin
                            n_field_cnt = '0;
                            n_phase     = lrdc_pkg::PH_CRC;
                        end else begin
                            n_field_cnt = cnt_next[31:0];
                        end
                        case (r_field_cnt)
                            32'd0: n_rec_op = i_log_byte;
                            32'd1: n_key_len[7:0]  = i_log_byte;
                            32'd2: n_key_len[15:8] = i_log_byte;
                            32'd3: n_val_len[7:0]   = i_log_byte;
                            32'd4: n_val_len[15:8]  = i_log_byte;
                            32'd5: n_val_len[23:16] = i_log_byte;
                            32'd6: begin
                                n_val_len = val_len_new;
                                n_key_end = 17'(lrdc_pkg::HDR_BYTES) + {1'b0, r_key_len};
                                n_val_end = 33'(lrdc_pkg::HDR_BYTES)
                                          + {17'd0, r_key_len} + {1'b0, val_len_new};
                                o_res_valid        = 1'b1;
                                o_res.ev           = lrdc_pkg::EV_HEADER;
                                o_res.op_code      = r_rec_op;
                                o_res.key_length   = r_key_len;
                                o_res.value_length = val_len_new;
                            end
                            default: begin
                                if ({1'b0, r_field_cnt} < {16'd0, r_key_end}) begin
                                    o_res_valid        = 1'b1;
                                    o_res.ev           = lrdc_pkg::EV_KEY;
                                    o_res.payload_byte = i_log_byte;
                                end else if ({1'b0, r_field_cnt} < r_val_end) begin
                                    o_res_valid        = 1'b1;
                                    o_res.ev           = lrdc_pkg::EV_VALUE;
                                    o_res.payload_byte = i_log_byte;
                                end
                            end
                        endcase
                    end

                    // received CRC, then the record checks in priority order
                    lrdc_pkg::PH_CRC: begin
                        n_rx_crc = r_rx_crc;
                        for (int j = 0; j < 4; j++) begin
                            if (r_field_cnt[1:0] == j[1:0]) begin
                                n_rx_crc[8*j +: 8] = i_log_byte;
                            end
                        end
                        n_field_cnt = cnt_next[31:0];
                        if (r_field_cnt[1:0] == 2'd3) begin
                            if ((r_crc ^ lrdc_pkg::CRC_ONES) != rx_crc_new) begin
                                n_stop = lrdc_pkg::ST_CRC;
                            end else if (r_pay_size < 32'(lrdc_pkg::HDR_BYTES)) begin
                                n_stop = lrdc_pkg::ST_SHORT;
                            end else if (r_val_end != {1'b0, r_pay_size}) begin
                                n_stop = lrdc_pkg::ST_MISMATCH;
                            end else if (r_rec_op != r_put_op && r_rec_op != r_del_op) begin
                                n_stop = lrdc_pkg::ST_BAD_OP;
                            end else begin
                                n_good_end      = off_inc;
                                n_phase         = lrdc_pkg::PH_LEN;
                                n_field_cnt     = '0;
                                n_pay_size      = '0;
                                n_rec_op        = '0;
                                n_key_len       = '0;
                                n_val_len       = '0;
                                n_key_end       = '0;
                                n_val_end       = '0;
                                n_crc           = lrdc_pkg::CRC_ONES;
                                n_rx_crc        = '0;
                                o_res_valid     = 1'b1;
                                o_res.ev        = lrdc_pkg::EV_GOOD;
                                o_res.valid_end = inc_ext[VW-1:0];
                            end
                        end
                    end

                    default: ;
                endcase
            end
        end
    end

endmodule

`default_nettype wire

### sv/lrdc_queue.sv
// Back end: short result queue that decouples the parser from the receiver.
`default_nettype none

module lrdc_queue (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_wr,
    input  lrdc_pkg::t_result      i_wr_data,
    input  wire logic              i_rd,
    output logic                   o_full,
    output logic                   o_empty,
    output lrdc_pkg::t_result      o_rd_data
);

    localparam int DEPTH = lrdc_pkg::Q_DEPTH;
    localparam int AW    = lrdc_pkg::Q_AW;
    localparam int CW    = lrdc_pkg::Q_CW;

    lrdc_pkg::t_result r_mem [DEPTH];
    logic [AW-1:0]     r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]     r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]     r_count,  n_count;
    logic              wr_en;
    logic              rd_en;

    assign o_full    = (r_count == CW'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign wr_en     = i_wr && !o_full;
    assign rd_en     = i_rd && !o_empty;
    assign o_rd_data = r_mem[r_rd_ptr];

    // Pointer and count update
    always_comb begin
        n_wr_ptr = wr_en ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = rd_en ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count;
        if (wr_en && !rd_en) begin
            n_count = r_count + 1'b1;
        end else if (rd_en && !wr_en) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage, no reset
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

endmodule

`default_nettype wire

### sv/log_record_deframer_checker_unit.sv
// Top level of the write-ahead log record deframer and checker.
//
// Input channel: one item per log byte (i_kind = 0, byte on i_log_byte) or an
// end-of-log marker (i_kind = 1). An item is taken when push is high and full
// is low. Result channel: the oldest result sits on the o_* ports while empty
// is low and leaves when pop is high. Each input item gives zero or one result.
// The parser takes one item per clock while full is low; a result enters a
// 4-entry queue at the same edge and, with the queue empty, shows on the ports the next cycle.
// Throughput is one item per cycle while the receiver pops; when it stalls the
// queue fills and full rises after four pending results, with no item lost.
// The per-byte CRC step and the record-end checks close in the parser cycle.
// Configuration (put and delete op codes) is written through i_cfg_we, i_cfg_idx
// and i_cfg_data by the user only while the block is idle; the block does not enforce it.
// Synchronous reset (i_rst_n low) empties the queue, restores the op codes to
// 0 and 1, and returns the parser to the start of a record at offset zero.
`default_nettype none

module log_record_deframer_checker_unit #(
    parameter int OFFSET_BITS = 48
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_cfg_we,
    input  wire logic [0:0]   i_cfg_idx,
    input  wire logic [7:0]   i_cfg_data,
    input  wire logic         push,
    output logic              full,
    input  wire logic         i_kind,
    input  wire logic [7:0]   i_log_byte,
    output logic              empty,
    input  wire logic         pop,
    output logic [2:0]        o_event_res,
    output logic [7:0]        o_op_code,
    output logic [15:0]       o_key_length,
    output logic [31:0]       o_value_length,
    output logic [7:0]        o_payload_byte,
    output logic [2:0]        o_status,
    output logic [47:0]       o_valid_end
);

    logic              accept;
    logic              res_valid;
    lrdc_pkg::t_result res;
    lrdc_pkg::t_result q_out;

    assign accept = push && !full;

    lrdc_front #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_kind      (i_kind),
        .i_log_byte  (i_log_byte),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    lrdc_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (res_valid),
        .i_wr_data (res),
        .i_rd      (pop),
        .o_full    (full),
        .o_empty   (empty),
        .o_rd_data (q_out)
    );

    // Result fields
    assign o_event_res    = q_out.ev;
    assign o_op_code      = q_out.op_code;
    assign o_key_length   = q_out.key_length;
    assign o_value_length = q_out.value_length;
    assign o_payload_byte = q_out.payload_byte;
    assign o_status       = q_out.status;
    assign o_valid_end    = q_out.valid_end;

endmodule

`default_nettype wire

### sv/lrdc_checker.sv
// Port-level checker for the log record deframer checker, with its bind.
`default_nettype none
`include "log_record_deframer_checker_unit_defines.svh"

module lrdc_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        full,
    input wire logic        empty,
    input wire logic        pop,
    input wire logic [2:0]  o_event_res,
    input wire logic [7:0]  o_op_code,
    input wire logic [15:0] o_key_length,
    input wire logic [31:0] o_value_length,
    input wire logic [2:0]  o_status
);

    // A waiting item holds until taken
    `LRDC_ASSERT_NEXT(a_hold, i_clk, i_rst_n, !empty && !pop, !empty && $stable(o_event_res) && $stable(o_status), "result item changed while stalled")

    // Reset leaves the queue empty and open
    `LRDC_ASSERT_SAME(a_reset, i_clk, i_rst_n, $past(!i_rst_n), empty && !full, "queue not empty after reset")

    // Status only rides on a log end item
    `LRDC_ASSERT_SAME(a_status, i_clk, i_rst_n, !empty && o_event_res != lrdc_pkg::EV_END, o_status == 3'd0, "status set outside log end")

    // Header fields only ride on a header item
    `LRDC_ASSERT_SAME(a_header, i_clk, i_rst_n, !empty && o_event_res != lrdc_pkg::EV_HEADER, o_op_code == 8'd0 && o_key_length == 16'd0 && o_value_length == 32'd0, "header fields outside header")

endmodule

bind log_record_deframer_checker_unit lrdc_checker u_lrdc_checker (.*);

`default_nettype wire

### verif/testbench.sv
// Testbench for the log record deframer checker: directed and random log traffic.
`timescale 1ns / 1ps

module testbench;

    import lrdc_pkg::*;

    typedef logic [7:0] t_byte_q[$];

    // ways of ending the log on a bad record
    typedef enum int {
        BRK_CRC,
        BRK_SHORT,
        BRK_EMPTY,
        BRK_MISMATCH,
        BRK_BAD_OP,
        BRK_TORN_LEN,
        BRK_TORN_REC,
        BRK_TORN_CRC
    } t_break;

    localparam logic        KIND_DATA   = 1'b0;
    localparam logic        KIND_END    = 1'b1;
    localparam logic [47:0] OFFSET_MAX  = {48{1'b1}};
    localparam int          STALL_LIMIT = 4000;
    localparam int          PHASE_ITEMS = 200;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_cfg_we   = 1'b0;
    logic [0:0]  i_cfg_idx  = REG_PUT_OP;
    logic [7:0]  i_cfg_data = 8'h00;
    logic        push       = 1'b0;
    logic        i_kind     = KIND_DATA;
    logic [7:0]  i_log_byte = 8'h00;
    logic        pop        = 1'b0;
    logic        full;
    logic        empty;
    logic [2:0]  o_event_res;
    logic [7:0]  o_op_code;
    logic [15:0] o_key_length;
    logic [31:0] o_value_length;
    logic [7:0]  o_payload_byte;
    logic [2:0]  o_status;
    logic [47:0] o_valid_end;

    // predictor state
    t_phase      rec_phase     = PH_LEN;
    logic [31:0] rec_count     = '0;
    logic [31:0] rec_size      = '0;
    logic [7:0]  rec_op        = '0;
    logic [15:0] rec_key_len   = '0;
    logic [31:0] rec_val_len   = '0;
    logic [31:0] rec_crc       = CRC_ONES;
    logic [31:0] rec_crc_field = '0;
    logic [47:0] log_offset    = '0;
    logic [47:0] last_good_end = '0;
    t_status     halt_reason   = ST_CLEAN;
    logic [7:0]  cfg_put_op    = 8'h00;
    logic [7:0]  cfg_del_op    = 8'h01;

    t_result expected_events[$];
    int      mismatches    = 0;
    int      items_sent    = 0;
    int      send_idle_pct = 0;
    int      recv_idle_pct = 0;
    int      hold_cycles   = 0;

    log_record_deframer_checker_unit DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .push           (push),
        .full           (full),
        .i_kind         (i_kind),
        .i_log_byte     (i_log_byte),
        .empty          (empty),
        .pop            (pop),
        .o_event_res    (o_event_res),
        .o_op_code      (o_op_code),
        .o_key_length   (o_key_length),
        .o_value_length (o_value_length),
        .o_payload_byte (o_payload_byte),
        .o_status       (o_status),
        .o_valid_end    (o_valid_end)
    );

    always #10 i_clk = ~i_clk;

    // reflected CRC-32, one data bit at a time
    function automatic logic [31:0] crc32_update(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        logic        fb;
        c = crc;
        for (int n = 0; n < 8; n++) begin
            fb = c[0] ^ b[n];
            c  = c >> 1;
            if (fb) c = c ^ CRC_POLY;
        end
        return c;
    endfunction

    function automatic logic [31:0] payload_crc(input t_byte_q pl);
        logic [31:0] c;
        c = CRC_ONES;
        foreach (pl[n]) c = crc32_update(c, pl[n]);
        return c ^ CRC_ONES;
    endfunction

    function automatic void restart_record();
        rec_phase     = PH_LEN;
        rec_count     = '0;
        rec_size      = '0;
        rec_op        = '0;
        rec_key_len   = '0;
        rec_val_len   = '0;
        rec_crc       = CRC_ONES;
        rec_crc_field = '0;
    endfunction

    // Expected log event for one accepted item, if any
    function automatic void predict_log_event(input logic kind, input logic [7:0] b);
        t_result     r;
        logic        has;
        logic [31:0] pos;
        logic [31:0] k;
        logic [32:0] total;
        r   = '0;
        has = 1'b0;
        if (kind == KIND_END) begin
            // end of log: clean only at a record boundary
            if (halt_reason == ST_CLEAN) begin
                if (rec_phase == PH_LEN && rec_count != 0)
                    halt_reason = ST_TORN_LEN;
                else if (rec_phase != PH_LEN)
                    halt_reason = ST_TORN_REC;
            end
            r.ev        = EV_END;
            r.status    = halt_reason;
            r.valid_end = last_good_end;
            has         = 1'b1;
        end else if (halt_reason == ST_CLEAN) begin
            if (log_offset != OFFSET_MAX) log_offset++;
            case (rec_phase)
                PH_LEN: begin
                    rec_size[8*rec_count[1:0] +: 8] = b;
                    rec_count++;
                    if (rec_count >= 4) begin
                        rec_count = '0;
                        rec_phase = (rec_size == 0) ? PH_CRC : PH_PAY;
                    end
                end
                PH_PAY: begin
                    pos     = rec_count;
                    rec_crc = crc32_update(rec_crc, b);
                    rec_count++;
                    if (rec_count >= rec_size) begin
                        rec_count = '0;
                        rec_phase = PH_CRC;
                    end
                    if (pos == 0) begin
                        rec_op = b;
                    end else if (pos < 3) begin
                        rec_key_len[8*(pos-1) +: 8] = b;
                    end else if (pos < HDR_BYTES) begin
                        rec_val_len[8*(pos-3) +: 8] = b;
                        if (pos == HDR_BYTES - 1) begin
                            r.ev           = EV_HEADER;
                            r.op_code      = rec_op;
                            r.key_length   = rec_key_len;
                            r.value_length = rec_val_len;
                            has            = 1'b1;
                        end
                    end else begin
                        // payload bytes past key and value pass silently
                        k = pos - HDR_BYTES;
                        if (k < rec_key_len) begin
                            r.ev           = EV_KEY;
                            r.payload_byte = b;
                            has            = 1'b1;
                        end else if (k - rec_key_len < rec_val_len) begin
                            r.ev           = EV_VALUE;
                            r.payload_byte = b;
                            has            = 1'b1;
                        end
                    end
                end
                PH_CRC: begin
                    rec_crc_field[8*rec_count[1:0] +: 8] = b;
                    rec_count++;
                    if (rec_count >= 4) begin
                        // record checks, first failure wins
                        total = 33'(HDR_BYTES) + rec_key_len + rec_val_len;
                        if ((rec_crc ^ CRC_ONES) != rec_crc_field) begin
                            halt_reason = ST_CRC;
                        end else if (rec_size < HDR_BYTES) begin
                            halt_reason = ST_SHORT;
                        end else if (total != {1'b0, rec_size}) begin
                            halt_reason = ST_MISMATCH;
                        end else if (rec_op != cfg_put_op && rec_op != cfg_del_op) begin
                            halt_reason = ST_BAD_OP;
                        end else begin
                            last_good_end = log_offset;
                            restart_record();
                            r.ev        = EV_GOOD;
                            r.valid_end = last_good_end;
                            has         = 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
        if (has) expected_events = {expected_events, r};
    endfunction

    function automatic void check_field(input string name, input logic [47:0] want,
                                        input logic [47:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // Predict on accepted items, compare accepted results
    always @(posedge i_clk) begin : log_event_check
        t_result want;
        if (i_rst_n && push && !full) predict_log_event(i_kind, i_log_byte);
        if (i_rst_n && pop && !empty) begin
            if (expected_events.size() == 0) begin
                $display("%0t: unexpected result, expected none actual event %0d",
                         $time, o_event_res);
                mismatches++;
            end else begin
                want = expected_events.pop_front();
                check_field("event_res", want.ev, o_event_res);
                check_field("op_code", want.op_code, o_op_code);
                check_field("key_length", want.key_length, o_key_length);
                check_field("value_length", want.value_length, o_value_length);
                check_field("payload_byte", want.payload_byte, o_payload_byte);
                check_field("status", want.status, o_status);
                check_field("valid_end", want.valid_end, o_valid_end);
            end
        end
    end

    // Receiver: random pops, or a counted hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else if (hold_cycles > 0) begin
            pop <= 1'b0;
            hold_cycles--;
        end else begin
            pop <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Watchdog: ends the run when nothing moves for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((push && !full) || (pop && !empty))
                quiet = 0;
            else
                quiet++;
        end
        $display("log_record_deframer_checker_unit verification failed");
        $finish;
    end

    task automatic send_log_item(input logic kind, input logic [7:0] b);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push       <= 1'b1;
        i_kind     <= kind;
        i_log_byte <= b;
        do @(posedge i_clk); while (full);
        items_sent++;
    endtask

    // Sender pause until every expected result is out
    task automatic wait_results_drained();
        push <= 1'b0;
        do @(posedge i_clk); while (expected_events.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_op_codes(input logic [7:0] put_op, input logic [7:0] del_op);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= REG_PUT_OP;
        i_cfg_data <= put_op;
        @(posedge i_clk);
        i_cfg_idx  <= REG_DEL_OP;
        i_cfg_data <= del_op;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        cfg_put_op = put_op;
        cfg_del_op = del_op;
    endtask

    function automatic t_byte_q make_payload(input logic [7:0] op, input logic [15:0] key_len,
                                             input logic [31:0] val_len, input int body_len);
        t_byte_q pl;
        pl = {op, key_len[7:0], key_len[15:8],
              val_len[7:0], val_len[15:8], val_len[23:16], val_len[31:24]};
        repeat (body_len) pl = {pl, 8'($urandom)};
        return pl;
    endfunction

    // Length field, payload, then the first crc_bytes bytes of the CRC field
    task automatic send_record(input t_byte_q pl, input logic [31:0] len_field,
                               input logic [31:0] crc_flip, input int crc_bytes);
        t_byte_q     frame;
        logic [31:0] crc;
        crc   = payload_crc(pl) ^ crc_flip;
        frame = {len_field[7:0], len_field[15:8], len_field[23:16], len_field[31:24]};
        foreach (pl[n]) frame = {frame, pl[n]};
        for (int n = 0; n < crc_bytes; n++) frame = {frame, crc[8*n +: 8]};
        foreach (frame[n]) send_log_item(KIND_DATA, frame[n]);
    endtask

    task automatic send_valid_record(input logic [7:0] op, input int key_len, input int val_len);
        t_byte_q pl;
        pl = make_payload(op, key_len, val_len, key_len + val_len);
        send_record(pl, pl.size(), 32'h0, 4);
    endtask

    function automatic int random_body_len();
        return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 6);
    endfunction

    // Defaults after reset: op codes 0 and 1, clean end of log
    task automatic test_reset_defaults();
        t_byte_q pl;
        send_idle_pct = 10;
        recv_idle_pct = 58;
        send_log_item(KIND_END, 8'h00);
        pl = {8'h00, 8'h01, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'hFF, 8'h00};
        send_record(pl, pl.size(), 32'h0, 4);
        send_valid_record(8'h01, 0, 0);
        send_log_item(KIND_END, 8'hFF);
        wait_results_drained();
    endtask

    // Extreme op codes through the register port
    task automatic test_register_writes();
        write_op_codes(8'hFF, 8'h00);
        send_valid_record(8'hFF, 2, 0);
        send_valid_record(8'h00, 0, 2);
        send_log_item(KIND_END, 8'h5A);
        wait_results_drained();
    endtask

    // Long receiver hold-off so the queue fills and full stalls the sender
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_cycles   = 300;
        send_valid_record(cfg_put_op, 40, 20);
        wait_results_drained();
    endtask

    task automatic run_traffic_phase(input int send_pct, input int recv_pct,
                                     input logic [7:0] put_op, input logic [7:0] del_op);
        int start;
        write_op_codes(put_op, del_op);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        start         = items_sent;
        while (items_sent - start < PHASE_ITEMS) begin
            send_valid_record($urandom_range(0, 1) ? cfg_put_op : cfg_del_op,
                              random_body_len(), random_body_len());
            if ($urandom_range(0, 9) == 0) send_log_item(KIND_END, 8'($urandom));
        end
        wait_results_drained();
    endtask

    // Well-formed records with random content, three idling profiles
    task automatic test_random_traffic();
        run_traffic_phase(10, 58, 8'($urandom), 8'($urandom));
        run_traffic_phase(58, 10, 8'h00, 8'hFF);
        run_traffic_phase(0, 0, 8'($urandom), 8'($urandom));
    endtask

    // One bad record ends parsing; later data is ignored, end of log repeats the reason
    task automatic test_stop_condition();
        t_break     mode;
        t_byte_q    pl;
        logic [7:0] op;
        send_idle_pct = 20;
        recv_idle_pct = 30;
        mode = t_break'($urandom_range(0, 7));
        case (mode)
            BRK_CRC: begin
                pl = make_payload(cfg_put_op, 3, 3, 6);
                send_record(pl, pl.size(), 32'h1 << $urandom_range(0, 31), 4);
            end
            BRK_SHORT: begin
                pl = {};
                repeat ($urandom_range(1, HDR_BYTES - 1)) pl = {pl, 8'($urandom)};
                send_record(pl, pl.size(), 32'h0, 4);
            end
            BRK_EMPTY: begin
                pl = {};
                send_record(pl, 32'h0, 32'h0, 4);
            end
            BRK_MISMATCH: begin
                // full-range header lengths, payload longer or shorter than declared
                pl = make_payload(cfg_del_op, 16'($urandom), $urandom, $urandom_range(0, 30));
                send_record(pl, pl.size(), 32'h0, 4);
            end
            BRK_BAD_OP: begin
                op = 8'($urandom);
                while (op == cfg_put_op || op == cfg_del_op) op++;
                pl = make_payload(op, 2, 2, 4);
                send_record(pl, pl.size(), 32'h0, 4);
            end
            BRK_TORN_LEN: begin
                repeat ($urandom_range(1, 3)) send_log_item(KIND_DATA, 8'($urandom));
                send_log_item(KIND_END, 8'($urandom));
            end
            BRK_TORN_REC: begin
                pl = make_payload(8'($urandom), 16'($urandom), $urandom, 10);
                send_record(pl, $urandom, 32'h0, 0);
                send_log_item(KIND_END, 8'($urandom));
            end
            default: begin
                pl = make_payload(cfg_put_op, 1, 1, 2);
                send_record(pl, pl.size(), 32'h0, $urandom_range(1, 3));
                send_log_item(KIND_END, 8'($urandom));
            end
        endcase
        repeat (40) send_log_item($urandom_range(0, 4) == 0, 8'($urandom));
        send_log_item(KIND_END, 8'($urandom));
    endtask

    initial begin : main
        int waited;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_register_writes();
        test_backpressure();
        test_random_traffic();
        test_stop_condition();

        // drain with a limit, then allow the result latency
        push <= 1'b0;
        waited = 0;
        while (expected_events.size() != 0 && waited < STALL_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (expected_events.size() != 0) begin
            $display("log_record_deframer_checker_unit verification failed");
        end else begin
            repeat (8) @(posedge i_clk);
            if (mismatches == 0 && expected_events.size() == 0)
                $display("log_record_deframer_checker_unit verification clean");
            else
                $display("log_record_deframer_checker_unit verification failed");
        end
        $finish;
    end

endmodule
